/* rtl/gtcw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gtcw_pkg: shared types and constants of the glyph window generator
// Holds the 6x8 font ROM, coordinate widths, register indexes and the
// window type that passes between the cell sequencer and the output stage.
// ----------------------------------------------------------------------------
package gtcw_pkg;

    // Font ROM geometry and the range of codes it holds.
    localparam int ROM_COLUMNS = 6;
    localparam int ROM_ROWS    = 8;
    localparam int ROM_IDX_W   = 3;
    localparam int FIRST_CODE  = 32;
    localparam int LAST_CODE   = 126;

    // Default glyph scan size.
    localparam int GLYPH_COLUMNS_DEF = 6;
    localparam int GLYPH_ROWS_DEF    = 8;

    // Signed cell coordinate width: a 16-bit position plus up to 16 scaled cells.
    localparam int COORD_W = 19;

    // Register reset values.
    localparam logic [8:0] SCREEN_WIDTH_RST  = 9'd135;
    localparam logic [8:0] SCREEN_HEIGHT_RST = 9'd240;
    localparam logic [7:0] COL_OFFSET_RST    = 8'd52;
    localparam logic [7:0] ROW_OFFSET_RST    = 8'd40;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1,
        REG_COL_OFFSET    = 2'd2,
        REG_ROW_OFFSET    = 2'd3
    } reg_index_t;

    // One glyph: column 0 is the leftmost byte, bit 0 of a byte is the top row.
    typedef logic [0:ROM_COLUMNS-1][7:0] glyph_t;

    // One panel window with its fill color.
    typedef struct packed {
        logic [15:0] fill_color;
        logic [9:0]  y_end;
        logic [9:0]  y_start;
        logic [9:0]  x_end;
        logic [9:0]  x_start;
    } win_t;

    // Font lookup; every code outside the printable range gets the question mark.
    function automatic glyph_t font_glyph(input logic [7:0] code);
        glyph_t g;
        unique case (code)
            8'h20: g = 48'h000000000000;
            8'h21: g = 48'h00005F000000;
            8'h22: g = 48'h000700070000;
            8'h23: g = 48'h147F147F1400;
            8'h24: g = 48'h242A7F2A1200;
            8'h25: g = 48'h231308646200;
            8'h26: g = 48'h364955225000;
            8'h27: g = 48'h000503000000;
            8'h28: g = 48'h001C22410000;
            8'h29: g = 48'h0041221C0000;
            8'h2A: g = 48'h082A1C2A0800;
            8'h2B: g = 48'h08083E080800;
            8'h2C: g = 48'h005030000000;
            8'h2D: g = 48'h080808080800;
            8'h2E: g = 48'h006060000000;
            8'h2F: g = 48'h201008040200;
            8'h30: g = 48'h3E5149453E00;
            8'h31: g = 48'h00427F400000;
            8'h32: g = 48'h426151494600;
            8'h33: g = 48'h2141454B3100;
            8'h34: g = 48'h1814127F1000;
            8'h35: g = 48'h274545453900;
            8'h36: g = 48'h3C4A49493000;
            8'h37: g = 48'h017109050300;
            8'h38: g = 48'h364949493600;
            8'h39: g = 48'h064949291E00;
            8'h3A: g = 48'h003636000000;
            8'h3B: g = 48'h005636000000;
            8'h3C: g = 48'h000814224100;
            8'h3D: g = 48'h141414141400;
            8'h3E: g = 48'h412214080000;
            8'h3F: g = 48'h020151090600;
            8'h40: g = 48'h324979413E00;
            8'h41: g = 48'h7E1111117E00;
            8'h42: g = 48'h7F4949493600;
            8'h43: g = 48'h3E4141412200;
            8'h44: g = 48'h7F4141221C00;
            8'h45: g = 48'h7F4949494100;
            8'h46: g = 48'h7F0909010100;
            8'h47: g = 48'h3E4141513200;
            8'h48: g = 48'h7F0808087F00;
            8'h49: g = 48'h00417F410000;
            8'h4A: g = 48'h2040413F0100;
            8'h4B: g = 48'h7F0814224100;
            8'h4C: g = 48'h7F4040404000;
            8'h4D: g = 48'h7F0204027F00;
            8'h4E: g = 48'h7F0408107F00;
            8'h4F: g = 48'h3E4141413E00;
            8'h50: g = 48'h7F0909090600;
            8'h51: g = 48'h3E4151215E00;
            8'h52: g = 48'h7F0919294600;
            8'h53: g = 48'h464949493100;
            8'h54: g = 48'h01017F010100;
            8'h55: g = 48'h3F4040403F00;
            8'h56: g = 48'h1F2040201F00;
            8'h57: g = 48'h7F2018207F00;
            8'h58: g = 48'h631408146300;
            8'h59: g = 48'h030478040300;
            8'h5A: g = 48'h615149454300;
            8'h5B: g = 48'h00007F414100;
            8'h5C: g = 48'h020408102000;
            8'h5D: g = 48'h41417F000000;
            8'h5E: g = 48'h040201020400;
            8'h5F: g = 48'h404040404000;
            8'h60: g = 48'h000102040000;
            8'h61: g = 48'h205454547800;
            8'h62: g = 48'h7F4844443800;
            8'h63: g = 48'h384444442000;
            8'h64: g = 48'h384444487F00;
            8'h65: g = 48'h385454541800;
            8'h66: g = 48'h087E09010200;
            8'h67: g = 48'h081454543C00;
            8'h68: g = 48'h7F0804047800;
            8'h69: g = 48'h00447D400000;
            8'h6A: g = 48'h2040443D0000;
            8'h6B: g = 48'h007F10284400;
            8'h6C: g = 48'h00417F400000;
            8'h6D: g = 48'h7C0418047800;
            8'h6E: g = 48'h7C0804047800;
            8'h6F: g = 48'h384444443800;
            8'h70: g = 48'h7C1414140800;
            8'h71: g = 48'h081414187C00;
            8'h72: g = 48'h7C0804040800;
            8'h73: g = 48'h485454542000;
            8'h74: g = 48'h043F44402000;
            8'h75: g = 48'h3C4040207C00;
            8'h76: g = 48'h1C2040201C00;
            8'h77: g = 48'h3C4030403C00;
            8'h78: g = 48'h442810284400;
            8'h79: g = 48'h0C5050503C00;
            8'h7A: g = 48'h4464544C4400;
            8'h7B: g = 48'h000836410000;
            8'h7C: g = 48'h00007F000000;
            8'h7D: g = 48'h004136080000;
            8'h7E: g = 48'h08082A1C0800;
            // Control codes and the upper half fall back to the question mark.
            default: g = 48'h020151090600;
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

/* rtl/glyph_to_clipped_windows.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_to_clipped_windows: bitmap character to clipped panel windows
// Turns one character draw request into a list of filled panel windows,
// one per visible glyph cell, with the final window marked by tlast.
// ----------------------------------------------------------------------------
// Usage:
//   A request word enters on the s_ channel and is taken only while the block
//   is idle. The glyph is scanned column by column, top row first, one cell
//   per cycle through one clip unit per axis while the output does not stall;
//   after the last cell the block flushes the pending window before it
//   returns to idle. Each kept window is held one step in a pending register
//   so that the last one can carry tlast, and from there it moves to the
//   output register. A character with no visible cell sends nothing.
//   When the m_ receiver stalls, the output register holds its word and the
//   scan waits on the cell that needs the pending slot, so nothing is lost.
//   Configuration words are always taken; they are meant to be written only
//   while no character is in flight. Reset loads the default screen size and
//   panel offsets, empties the output and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module glyph_to_clipped_windows
    import gtcw_pkg::*;
#(
    parameter int GLYPH_COLUMNS = GLYPH_COLUMNS_DEF,
    parameter int GLYPH_ROWS    = GLYPH_ROWS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Request: x_pos[15:0], y_pos[31:16], char_code[39:32], fg_color[55:40],
    // bg_color[71:56], scale[79:72].
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,
    // Window: win_x_start[9:0], win_x_end[19:10], win_y_start[29:20],
    // win_y_end[39:30], fill_color[55:40].
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,
    output logic             m_tlast,
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data
);

    localparam int COL_W = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;
    localparam int ROW_W = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(GLYPH_COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } state_t;

    state_t                    state_reg;
    logic [COL_W-1:0]          col_reg;
    logic [ROW_W-1:0]          row_reg;
    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic [7:0]                s_reg;
    logic [15:0]               fg_reg;
    logic [15:0]               bg_reg;
    glyph_t                    glyph_reg;
    logic                      pend_valid_reg;
    win_t                      pend_reg;
    logic                      out_valid_reg;
    win_t                      out_reg;
    logic                      out_last_reg;
    logic [8:0]                screen_width_reg;
    logic [8:0]                screen_height_reg;
    logic [7:0]                col_offset_reg;
    logic [7:0]                row_offset_reg;

    logic                      accept;
    logic                      out_free;
    logic [3:0]                col_ext;
    logic [3:0]                row_ext;
    logic [7:0]                col_bits;
    logic                      bit_set;
    logic                      cell_on;
    logic                      x_keep;
    logic                      y_keep;
    logic                      hit;
    logic                      adv;
    logic                      move_out;
    logic                      row_wrap;
    logic                      col_wrap;
    logic signed [COORD_W-1:0] s_ext;
    win_t                      cell_win;

    // Ports.
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;
    assign m_tlast   = out_last_reg;
    assign out_free  = !out_valid_reg || m_tready;

    // Glyph bit of the current cell; cells past the ROM read as clear.
    assign col_ext = 4'(col_reg);
    assign row_ext = 4'(row_reg);
    assign col_bits = (col_ext < 4'(ROM_COLUMNS)) ? glyph_reg[col_ext[ROM_IDX_W-1:0]] : 8'h00;
    assign bit_set  = (row_ext < 4'(ROM_ROWS)) && col_bits[row_ext[2:0]];
    assign cell_on  = bit_set || (bg_reg != fg_reg);

    // One clip unit per axis, one cell per cycle while the scan is not stalled.
    gtcw_span_clip u_clip_x (
        .lo         (cx_reg),
        .len        (s_reg),
        .limit      (screen_width_reg),
        .offset     (col_offset_reg),
        .keep       (x_keep),
        .span_start (cell_win.x_start),
        .span_end   (cell_win.x_end)
    );

    gtcw_span_clip u_clip_y (
        .lo         (cy_reg),
        .len        (s_reg),
        .limit      (screen_height_reg),
        .offset     (row_offset_reg),
        .keep       (y_keep),
        .span_start (cell_win.y_start),
        .span_end   (cell_win.y_end)
    );

    assign cell_win.fill_color = bit_set ? fg_reg : bg_reg;
    assign hit = cell_on && x_keep && y_keep;

    // Scan step: a kept cell may only push out the pending window when the
    // output register has room.
    assign adv      = (state_reg == ST_RUN) && (!(hit && pend_valid_reg) || out_free);
    assign move_out = (adv && hit && pend_valid_reg)
                   || ((state_reg == ST_FLUSH) && pend_valid_reg && out_free);
    assign row_wrap = (row_reg == ROW_LAST);
    assign col_wrap = (col_reg == COL_LAST);
    assign s_ext    = signed'({{(COORD_W-8){1'b0}}, s_reg});

    // Sequencer, output register and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            col_reg           <= '0;
            row_reg           <= '0;
            pend_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
            out_reg           <= '0;
            out_last_reg      <= 1'b0;
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
            col_offset_reg    <= COL_OFFSET_RST;
            row_offset_reg    <= ROW_OFFSET_RST;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                    REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                    REG_COL_OFFSET:    col_offset_reg    <= cfg_data[7:0];
                    REG_ROW_OFFSET:    row_offset_reg    <= cfg_data[7:0];
                    default:           ;
                endcase
            end

            if (move_out)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= pend_reg;
                out_last_reg  <= (state_reg == ST_FLUSH);
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (adv && hit)
                pend_valid_reg <= 1'b1;
            else if (state_reg == ST_FLUSH && out_free)
                pend_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_RUN;
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                end
                ST_RUN:
                begin
                    if (adv)
                    begin
                        if (row_wrap)
                        begin
                            row_reg <= '0;
                            if (col_wrap)
                                state_reg <= ST_FLUSH;
                            else
                                col_reg <= col_reg + COL_W'(1);
                        end
                        else
                        begin
                            row_reg <= row_reg + ROW_W'(1);
                        end
                    end
                end
                ST_FLUSH:
                begin
                    if (!pend_valid_reg || out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Request fields, cell coordinates and the pending window.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg    <= COORD_W'(signed'(s_tdata[15:0]));
            cy_reg    <= COORD_W'(signed'(s_tdata[31:16]));
            y_reg     <= COORD_W'(signed'(s_tdata[31:16]));
            glyph_reg <= font_glyph(s_tdata[39:32]);
            fg_reg    <= s_tdata[55:40];
            bg_reg    <= s_tdata[71:56];
            s_reg     <= (s_tdata[79:72] == 8'd0) ? 8'd1 : s_tdata[79:72];
        end
        else if (adv)
        begin
            if (row_wrap)
            begin
                cy_reg <= y_reg;
                cx_reg <= cx_reg + s_ext;
            end
            else
            begin
                cy_reg <= cy_reg + s_ext;
            end
        end

        if (adv && hit)
            pend_reg <= cell_win;
    end

    // A new request only starts with an empty pending slot.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !pend_valid_reg)
        else $error("request taken while a window is still pending");

    // A stalled cell that needs the pending slot holds its place.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && hit && pend_valid_reg && out_valid_reg && !m_tready)
        |=> ($stable(col_reg) && $stable(row_reg) && state_reg == ST_RUN))
        else $error("scan moved past a cell while the output was stalled");

    // The scan always starts at the first cell.
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RUN && col_reg == '0 && row_reg == '0))
        else $error("scan did not start at the first cell");

    // A flush with nothing pending returns to idle at once.
    a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && !pend_valid_reg) |=> (state_reg == ST_IDLE))
        else $error("empty flush did not return to idle");

endmodule
`default_nettype wire

/* rtl/gtcw_span_clip.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gtcw_span_clip: clip one scaled cell span to the screen
// Takes the span [lo, lo+len-1], clips it to [0, limit-1], reports whether
// anything remains, and returns both ends moved by the panel offset.
// ----------------------------------------------------------------------------
module gtcw_span_clip
    import gtcw_pkg::*;
(
    input  wire logic signed [COORD_W-1:0] lo,
    input  wire logic        [7:0]         len,
    input  wire logic        [8:0]         limit,
    input  wire logic        [7:0]         offset,
    output logic                           keep,
    output logic             [9:0]         span_start,
    output logic             [9:0]         span_end
);

    logic signed [COORD_W:0] lo_ext;
    logic signed [COORD_W:0] hi_pos;
    logic signed [COORD_W:0] top;
    logic signed [COORD_W:0] lo_c;
    logic signed [COORD_W:0] hi_c;

    // Raw span end and the last visible coordinate.
    assign lo_ext = {lo[COORD_W-1], lo};
    assign hi_pos = lo_ext + signed'({{(COORD_W+1-8){1'b0}}, len}) - (COORD_W+1)'(1);
    assign top    = signed'({{(COORD_W+1-9){1'b0}}, limit}) - (COORD_W+1)'(1);

    // Clamp both ends; the span survives only if they stay in order.
    assign lo_c = lo_ext[COORD_W] ? '0 : lo_ext;
    assign hi_c = (hi_pos > top) ? top : hi_pos;
    assign keep = (lo_c <= hi_c);

    // A kept span lies in 0..510, so nine bits carry it before the offset.
    assign span_start = {1'b0, lo_c[8:0]} + {2'b00, offset};
    assign span_end   = {1'b0, hi_c[8:0]} + {2'b00, offset};

endmodule
`default_nettype wire
